### rtl/cal_pkg.sv
package cal_pkg;

	typedef enum logic [3:0] {
		ACT_CLEAR  = 4'd0,
		ACT_INSERT = 4'd1,
		ACT_APPEND = 4'd2,
		ACT_REMOVE = 4'd3,
		ACT_SORTED = 4'd4,
		ACT_START  = 4'd5,
		ACT_END    = 4'd6,
		ACT_NEXT   = 4'd7,
		ACT_PREV   = 4'd8,
		ACT_SEEK   = 4'd9,
		ACT_READ   = 4'd10,
		ACT_WRITE  = 4'd11
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOELEM = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_WRITE  = 2'd3
	} cell_op_t;

	localparam int ACTION_W   = 4;
	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 4;
	localparam int LENGTH_W   = 5;
	localparam int CURSOR_W   = 5;
	localparam int STATUS_W   = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

endpackage

### rtl/cal_cell.sv
module cal_cell #(
	parameter int IDX        = 0,
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  cal_pkg::cell_op_t                 op,
	input  logic [$clog2(CAPACITY+1)-1:0]     pos,
	input  logic [$clog2(CAPACITY+1)-1:0]     len,
	input  logic [DATA_WIDTH-1:0]             wr_value,
	input  logic [DATA_WIDTH-1:0]             cmp_value,
	input  logic [DATA_WIDTH-1:0]             left_data,
	input  logic [DATA_WIDTH-1:0]             right_data,
	input  logic [$clog2(CAPACITY+1)-1:0]     rd_index,
	output logic [DATA_WIDTH-1:0]             data,
	output logic                              gt,
	output logic [DATA_WIDTH-1:0]             rd_tap
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			cal_pkg::CELL_INSERT: begin
				if (IDX_C == pos) begin
					data_q <= wr_value;
				end else if (IDX_C > pos && IDX_C <= len) begin
					data_q <= left_data;
				end
			end
			cal_pkg::CELL_REMOVE: begin
				if (IDX_C >= pos && NEXT_C < len) begin
					data_q <= right_data;
				end
			end
			cal_pkg::CELL_WRITE: begin
				if (IDX_C == pos) begin
					data_q <= wr_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign data   = data_q;
	assign gt     = (IDX_C < len) && (data_q > cmp_value);
	assign rd_tap = (IDX_C == rd_index) ? data_q : '0;

endmodule

### rtl/cal_chain.sv
module cal_chain #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  cal_pkg::cell_op_t                 op,
	input  logic [$clog2(CAPACITY+1)-1:0]     pos,
	input  logic [$clog2(CAPACITY+1)-1:0]     len,
	input  logic [DATA_WIDTH-1:0]             wr_value,
	input  logic [DATA_WIDTH-1:0]             cmp_value,
	input  logic [$clog2(CAPACITY+1)-1:0]     rd_index,
	output logic [CAPACITY-1:0]               gt,
	output logic [DATA_WIDTH-1:0]             rd_data
);

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		cal_cell #(
			.IDX        (i),
			.CAPACITY   (CAPACITY),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos),
			.len        (len),
			.wr_value   (wr_value),
			.cmp_value  (cmp_value),
			.left_data  (left_w),
			.right_data (right_w),
			.rd_index   (rd_index),
			.data       (cell_data[i]),
			.gt         (gt[i]),
			.rd_tap     (cell_tap[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_tap[i];
		end
	end

endmodule

### rtl/cursor_array_list_core.sv
// Array list of up to CAPACITY entries with a cursor, built as a row of cells.
// The input stream carries one action per transaction: action in tdata[3:0],
// value in tdata[35:4] and position in tdata[39:36]. Every accepted
// transaction produces exactly one output transaction with result_value,
// list_length, cursor_index and status.
// An accepted transaction is held in the first stage, and the block takes no
// new transaction until that one has executed. On acceptance every cell
// compares its entry with the incoming value and the entry under the cursor
// is read out, and both are registered; when the action executes, the cells
// shift, load or hold as one row and the result goes to the output register.
// The output register lets the next transaction be accepted while a result
// still waits. When the receiver stalls, the pending action holds in the
// first stage and s_axis_tready stays low until the output register frees.
// Reset clears the length, the cursor and all valid flags; the entries keep
// unknown contents and only entries below the length are ever read.
module cursor_array_list_core #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[3:0], value[35:4], position[39:36]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_value[31:0], list_length[36:32], cursor_index[41:37],
	// status[43:42], zero padding[47:44]
	output logic [47:0] m_axis_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = (DATA_WIDTH > cal_pkg::VALUE_W) ? DATA_WIDTH : cal_pkg::VALUE_W;
	localparam int XW = (CW > cal_pkg::POSITION_W) ? CW : cal_pkg::POSITION_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [CW-1:0] length_q;
	logic [CW-1:0] cursor_q;

	logic                                v_s1;
	logic [cal_pkg::ACTION_W-1:0]        act_s1;
	logic [DATA_WIDTH-1:0]               val_s1;
	logic [cal_pkg::POSITION_W-1:0]      pos_s1;
	logic [CAPACITY-1:0]                 gt_s1;
	logic [DATA_WIDTH-1:0]               rd_s1;

	logic                                out_valid_q;
	logic [cal_pkg::VALUE_W-1:0]         out_value_q;
	logic [cal_pkg::LENGTH_W-1:0]        out_length_q;
	logic [cal_pkg::CURSOR_W-1:0]        out_cursor_q;
	cal_pkg::status_t                    out_status_q;

	logic [cal_pkg::ACTION_W-1:0]   in_action;
	logic [cal_pkg::VALUE_W-1:0]    in_value;
	logic [cal_pkg::POSITION_W-1:0] in_position;
	logic [VW-1:0]                  in_value_ext;
	logic [DATA_WIDTH-1:0]          in_entry;

	logic                  in_accept;
	logic                  exec;
	logic [CAPACITY-1:0]   gt_w;
	logic [DATA_WIDTH-1:0] rd_w;
	logic [CAPACITY-1:0]   first_gt;
	logic [CW-1:0]         gt_idx;
	logic [CW-1:0]         sorted_pos;
	logic                  is_full;
	logic                  no_elem;
	logic                  seek_ok;

	cal_pkg::cell_op_t op_c;
	cal_pkg::cell_op_t cell_op;
	logic [CW-1:0]     op_pos;
	logic [CW-1:0]     cell_pos;
	logic [CW-1:0]     length_n;
	logic [CW-1:0]     cursor_n;
	logic [DATA_WIDTH-1:0] result_n;
	cal_pkg::status_t  status_n;
	logic [VW-1:0]     result_ext;

	assign in_action    = s_axis_tdata[3:0];
	assign in_value     = s_axis_tdata[35:4];
	assign in_position  = s_axis_tdata[39:36];
	assign in_value_ext = VW'(in_value);
	assign in_entry     = in_value_ext[DATA_WIDTH-1:0];

	assign s_axis_tready = !v_s1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign exec          = v_s1 && (!out_valid_q || m_axis_tready);

	cal_chain #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_chain (
		.clk       (clk),
		.op        (cell_op),
		.pos       (cell_pos),
		.len       (length_q),
		.wr_value  (val_s1),
		.cmp_value (in_entry),
		.rd_index  (cursor_q),
		.gt        (gt_w),
		.rd_data   (rd_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (exec) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_s1 <= in_action;
			val_s1 <= in_entry;
			pos_s1 <= in_position;
			gt_s1  <= gt_w;
			rd_s1  <= rd_w;
		end
	end

	assign first_gt = gt_s1 & (~gt_s1 + CAPACITY'(1));

	always_comb begin
		gt_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_gt[i]) begin
				gt_idx = gt_idx | CW'(i);
			end
		end
	end

	assign sorted_pos = (gt_s1 == '0) ? length_q : gt_idx;
	assign is_full    = (length_q == CAP_C);
	assign no_elem    = (cursor_q >= length_q);
	assign seek_ok    = (XW'(pos_s1) < XW'(length_q));

	always_comb begin
		op_c     = cal_pkg::CELL_HOLD;
		op_pos   = cursor_q;
		length_n = length_q;
		cursor_n = cursor_q;
		result_n = '0;
		status_n = cal_pkg::ST_OK;
		case (act_s1)
			cal_pkg::ACT_CLEAR: begin
				length_n = '0;
				cursor_n = '0;
			end
			cal_pkg::ACT_INSERT: begin
				if (is_full) begin
					status_n = cal_pkg::ST_FULL;
				end else begin
					op_c     = cal_pkg::CELL_INSERT;
					length_n = length_q + ONE_C;
				end
			end
			cal_pkg::ACT_APPEND: begin
				if (is_full) begin
					status_n = cal_pkg::ST_FULL;
				end else begin
					op_c     = cal_pkg::CELL_INSERT;
					op_pos   = length_q;
					length_n = length_q + ONE_C;
				end
			end
			cal_pkg::ACT_REMOVE: begin
				if (no_elem) begin
					status_n = cal_pkg::ST_NOELEM;
				end else begin
					op_c     = cal_pkg::CELL_REMOVE;
					result_n = rd_s1;
					length_n = length_q - ONE_C;
				end
			end
			cal_pkg::ACT_SORTED: begin
				if (is_full) begin
					status_n = cal_pkg::ST_FULL;
				end else begin
					op_c     = cal_pkg::CELL_INSERT;
					op_pos   = sorted_pos;
					cursor_n = sorted_pos;
					length_n = length_q + ONE_C;
				end
			end
			cal_pkg::ACT_START: begin
				cursor_n = '0;
			end
			cal_pkg::ACT_END: begin
				cursor_n = length_q;
			end
			cal_pkg::ACT_NEXT: begin
				if (cursor_q < length_q) begin
					cursor_n = cursor_q + ONE_C;
				end
			end
			cal_pkg::ACT_PREV: begin
				if (cursor_q != '0) begin
					cursor_n = cursor_q - ONE_C;
				end
			end
			cal_pkg::ACT_SEEK: begin
				if (seek_ok) begin
					cursor_n = CW'(pos_s1);
				end else begin
					status_n = cal_pkg::ST_RANGE;
				end
			end
			cal_pkg::ACT_READ: begin
				if (no_elem) begin
					status_n = cal_pkg::ST_NOELEM;
				end else begin
					result_n = rd_s1;
				end
			end
			cal_pkg::ACT_WRITE: begin
				if (no_elem) begin
					status_n = cal_pkg::ST_NOELEM;
				end else begin
					op_c = cal_pkg::CELL_WRITE;
				end
			end
			default: begin
			end
		endcase
	end

	assign cell_op    = exec ? op_c : cal_pkg::CELL_HOLD;
	assign cell_pos   = op_pos;
	assign result_ext = VW'(result_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				length_q    <= length_n;
				cursor_q    <= cursor_n;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_value_q  <= result_ext[cal_pkg::VALUE_W-1:0];
			out_length_q <= cal_pkg::LENGTH_W'(length_n);
			out_cursor_q <= cal_pkg::CURSOR_W'(cursor_n);
			out_status_q <= status_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_status_q, out_cursor_q, out_length_q, out_value_q};

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= length_q)
		else $error("cursor beyond list length");

	a_length_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= CAP_C)
		else $error("list length beyond capacity");

	a_result_follows_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s1))
		else $error("result appeared without a pending transaction");

	a_state_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(length_q) && $stable(cursor_q)))
		else $error("list state changed while the output was stalled");

endmodule
